FILE: sv/percent_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// percent_decoder_core_assert.svh
// Assertion macros used by the percent decoder core.
// ----------------------------------------------------------------------------
`ifndef PERCENT_DECODER_CORE_ASSERT_SVH
`define PERCENT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PCTDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("percent decoder assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PCTDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("percent decoder assertion failed");

`endif

FILE: sv/pctdec_pkg.sv
// ----------------------------------------------------------------------------
// pctdec_pkg
// Types and constants of the percent decoder.
// ----------------------------------------------------------------------------
package pctdec_pkg;

   localparam logic [7:0] PCT_CHAR  = 8'h25;
   localparam logic [7:0] NUL_CHAR  = 8'h00;

   // Position inside an escape sequence.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,   // outside any escape
      PH_HIGH = 2'd1,   // after '%', expecting the high digit
      PH_LOW  = 2'd2    // after the high digit, expecting the low digit
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] high_nibble;
      logic       stopped;
      logic       error_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_IDLE,
      high_nibble: 4'd0,
      stopped:     1'b0,
      error_seen:  1'b0
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       end_of_string;
      logic       error;
   } result_type;

endpackage

FILE: sv/pctdec_if.sv
// ----------------------------------------------------------------------------
// pctdec_if
// Valid/ready channels of the percent decoder: request and response.
// ----------------------------------------------------------------------------
interface pctdec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last;

   modport source (output valid, output in_byte, output last, input ready);
   modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface pctdec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       end_of_string;
   logic       error;

   modport source (output valid, output out_byte, output out_valid,
                   output end_of_string, output error, input ready);
   modport sink   (input valid, input out_byte, input out_valid,
                   input end_of_string, input error, output ready);
endinterface

FILE: sv/pctdec_decode.sv
// ----------------------------------------------------------------------------
// pctdec_decode
// Next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
module pctdec_decode (
   input  pctdec_pkg::state_type  state_cur,
   input  logic [7:0]             in_byte,
   input  logic                   last,
   output pctdec_pkg::state_type  state_nxt,
   output pctdec_pkg::result_type result
);
   import pctdec_pkg::*;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_value(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         // letters a-f and A-F share the low three bits: 1..6
         h.val = {1'b0, b[2:0]} + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   hex_type   digit;
   state_type nxt;
   logic      emit;
   logic [7:0] emit_byte;

   assign digit = hex_value(in_byte);

   always_comb begin
      nxt       = state_cur;
      emit      = 1'b0;
      emit_byte = 8'd0;
      if (!state_cur.stopped && !state_cur.error_seen) begin
         unique case (state_cur.phase)
            PH_HIGH: begin
               if (!digit.ok) begin
                  nxt.error_seen = 1'b1;
                  nxt.phase      = PH_IDLE;
               end else begin
                  nxt.high_nibble = digit.val;
                  nxt.phase       = PH_LOW;
               end
            end
            PH_LOW: begin
               nxt.phase = PH_IDLE;
               // reject non-hex and the encoded zero byte
               if (!digit.ok || (state_cur.high_nibble == 4'd0 && digit.val == 4'd0)) begin
                  nxt.error_seen = 1'b1;
               end else begin
                  emit      = 1'b1;
                  emit_byte = {state_cur.high_nibble, digit.val};
               end
            end
            default: begin
               nxt.phase = PH_IDLE;
               if (in_byte == PCT_CHAR) begin
                  nxt.phase = PH_HIGH;
               end else if (in_byte == NUL_CHAR) begin
                  nxt.stopped = 1'b1;
               end else begin
                  emit      = 1'b1;
                  emit_byte = in_byte;
               end
            end
         endcase
      end

      // string ends inside an escape
      if (last && nxt.phase != PH_IDLE && !nxt.stopped && !nxt.error_seen) begin
         nxt.error_seen = 1'b1;
      end

      result.out_byte      = emit_byte;
      result.out_valid     = emit;
      result.end_of_string = last;
      result.error         = nxt.error_seen;

      state_nxt = last ? STATE_RESET : nxt;
   end

endmodule

FILE: sv/percent_decoder_core.sv
// ----------------------------------------------------------------------------
// percent_decoder_core
// Streaming URL percent decoder, one encoded byte per item.
// ----------------------------------------------------------------------------
// Takes one raw byte per request item and returns exactly one response item
// for it, in order, at a sustained rate of one item per clock cycle while
// the response channel takes every item. Accepting a request loads the input
// register; the item then passes through the decode logic into the response
// register when that register is free or being taken, and is offered there.
// The decode state (escape phase, high digit, stopped and sticky error flags)
// is a single small register updated once per item, which is what sets the
// one-item-per-cycle figure. When error is set on a response, drop every
// byte of that string delivered so far; the flag stays set up to and
// including the response marked end_of_string, after which all state clears.
// req_chan.ready only falls when both stages hold items and the response
// is not being taken.
// ----------------------------------------------------------------------------
`include "percent_decoder_core_assert.svh"

module percent_decoder_core (
   input  logic         clock,
   input  logic         reset,
   pctdec_req_if.sink   req_chan,
   pctdec_rsp_if.source rsp_chan
);
   import pctdec_pkg::*;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // Decode state and response register
   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   result_type result;
   logic       pipe_move;   // response stage free or draining this cycle
   logic       s1_load;     // input register takes a new item
   logic       step;        // an item passes through the decode logic

   // Assertion terms
   logic       chk_last_step;
   logic       chk_err_step;
   logic       chk_emit_out;

   // Advance the whole pipe whenever the response register is free or taken.
   assign pipe_move = !rsp_valid_ff || rsp_chan.ready;
   assign s1_load   = pipe_move || !s1_valid_ff;
   assign step      = pipe_move && s1_valid_ff;

   assign req_chan.ready = s1_load;

   pctdec_decode u_decode (
      .state_cur (state_ff),
      .in_byte   (s1_byte_ff),
      .last      (s1_last_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_comb begin
      s1_valid_in  = s1_load ? req_chan.valid : s1_valid_ff;
      rsp_valid_in = pipe_move ? s1_valid_ff : rsp_valid_ff;
   end

   // Control: clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Commit the state update only for an item that actually advances.
         if (step) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload: hold while stalled, no reset needed.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_byte_ff <= req_chan.in_byte;
         s1_last_ff <= req_chan.last;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = rsp_ff.out_byte;
   assign rsp_chan.out_valid     = rsp_ff.out_valid;
   assign rsp_chan.end_of_string = rsp_ff.end_of_string;
   assign rsp_chan.error         = rsp_ff.error;

   assign chk_last_step = step && s1_last_ff;
   assign chk_err_step  = step && state_ff.error_seen && !s1_last_ff;
   assign chk_emit_out  = rsp_valid_ff && rsp_ff.out_valid;

   // The last item of a string leaves the decode state at its reset value.
   `PCTDEC_ASSERT_NEXT(a_clear_after_last, clock, reset, chk_last_step, state_ff == STATE_RESET)

   // The error flag is sticky within a string.
   `PCTDEC_ASSERT_NEXT(a_error_sticky, clock, reset, chk_err_step, state_ff.error_seen)

   // A decoded byte never goes out with the error flag set.
   `PCTDEC_ASSERT_NOW(a_no_emit_on_error, clock, reset, chk_emit_out, !rsp_ff.error)

   // A zero byte only stops the string from outside an escape.
   `PCTDEC_ASSERT_NOW(a_stopped_idle, clock, reset, state_ff.stopped, state_ff.phase == PH_IDLE)

endmodule
